// ===== src/rita_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rita_pkg
// shared types, constants and helpers of the radix integer-to-ascii converter
// ----------------------------------------------------------------------------
package rita_pkg;

    localparam int VALUE_W      = 31;
    localparam int RADIX_W      = 6;
    localparam int CHAR_W       = 7;
    localparam int MAX_DIGITS   = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0]  ALPHA_OFFSET = 7'd55;
    localparam logic [CHAR_W-1:0]  NUM_OFFSET   = 7'd48;
    localparam logic [RADIX_W-1:0] NUM_TOP      = 6'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_POP,
        ST_LOAD,
        ST_EMIT
    } t_state;

    // remainder to ascii digit
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d > NUM_TOP) begin
            return d_ext + ALPHA_OFFSET;
        end
        return d_ext + NUM_OFFSET;
    endfunction

    // clamp the radix register to the supported range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/rita_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rita_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rita_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/radix_integer_to_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// converts a non-negative integer to ascii digits in a programmable radix
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_ready carry one 31-bit value per beat
//   output channel: o_valid / i_ready carry one ascii digit per beat, most
//     significant first; o_last_digit marks the final (least significant) one
//   config: i_cfg_wr_en writes i_cfg_wr_data into the radix register; values
//     below 2 act as 2 and above 36 act as 36; write only while idle
// timing
//   one shared restoring divider produces one quotient bit per cycle, so each
//   digit takes a full pass over every dividend bit, then a push into the digit stack ram
//   popping runs a ram read, a load and an output beat for each digit; the
//   output beat holds while i_ready is low
//   o_ready is high only while idle: one value is converted at a time
// reset
//   synchronous active-low i_rst_n returns to idle, empties the stack and sets
//   the radix to 10; the stack ram itself is not cleared
// stalls
//   while i_ready is low the current digit beat holds; nothing else advances
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
    parameter int MAX_DIGITS = rita_pkg::MAX_DIGITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [rita_pkg::RADIX_W-1:0] i_cfg_wr_data,
    // input channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [rita_pkg::VALUE_W-1:0] i_value,
    // output channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [rita_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                              o_last_digit
);

    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int DW    = $clog2(MAX_DIGITS + 1);
    localparam int VW    = rita_pkg::VALUE_W;
    localparam int RW    = rita_pkg::RADIX_W;
    localparam int CW    = rita_pkg::CHAR_W;
    localparam int BW    = $clog2(VW);

    // control state
    rita_pkg::t_state r_state, n_state;
    logic [DW-1:0]    r_depth, n_depth;
    logic [RW-1:0]    r_radix;

    // datapath
    logic [RW-1:0]    r_radix_eff, n_radix_eff;
    logic [VW-1:0]    r_quo, n_quo;
    logic [RW-1:0]    r_rem, n_rem;
    logic [BW-1:0]    r_bit, n_bit;
    logic [CW-1:0]    r_out_char, n_out_char;
    logic             r_out_last, n_out_last;

    // divider step
    logic [RW:0]      step_shift;
    logic [RW:0]      step_diff;
    logic             step_ge;

    // stack ram
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [CW-1:0]    ram_rd_data;
    logic [DW-1:0]    depth_m1;

    // one restoring division step: bring in the next dividend bit
    assign step_shift = {r_rem, r_quo[VW-1]};
    assign step_diff  = step_shift - {1'b0, r_radix_eff};
    assign step_ge    = (step_shift >= {1'b0, r_radix_eff});
    assign depth_m1   = r_depth - DW'(1);

    // radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rita_pkg::RADIX_RESET;
        end else if (i_cfg_wr_en) begin
            r_radix <= i_cfg_wr_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rita_pkg::ST_IDLE;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_radix_eff <= n_radix_eff;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_bit       <= n_bit;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_radix_eff = r_radix_eff;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_depth[AW-1:0];
        ram_rd_en   = 1'b0;
        ram_rd_addr = depth_m1[AW-1:0];

        case (r_state)
            rita_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_radix_eff = rita_pkg::clamp_radix(r_radix);
                    n_quo       = i_value;
                    n_rem       = '0;
                    n_bit       = BW'(VW - 1);
                    n_depth     = '0;
                    n_state     = rita_pkg::ST_DIV;
                end
            end
            rita_pkg::ST_DIV: begin
                // quotient bits shift in where dividend bits leave
                n_quo = {r_quo[VW-2:0], step_ge};
                n_rem = step_ge ? step_diff[RW-1:0] : step_shift[RW-1:0];
                n_bit = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_state = rita_pkg::ST_PUSH;
                end
            end
            rita_pkg::ST_PUSH: begin
                // drop more significant digits once the stack is full
                if (r_depth < DW'(MAX_DIGITS)) begin
                    ram_wr_en = 1'b1;
                    n_depth   = r_depth + DW'(1);
                end
                n_rem = '0;
                n_bit = BW'(VW - 1);
                if (r_quo == '0) begin
                    n_state = rita_pkg::ST_POP;
                end else begin
                    n_state = rita_pkg::ST_DIV;
                end
            end
            rita_pkg::ST_POP: begin
                ram_rd_en = 1'b1;
                n_depth   = depth_m1;
                n_state   = rita_pkg::ST_LOAD;
            end
            rita_pkg::ST_LOAD: begin
                n_out_char = ram_rd_data;
                n_out_last = (r_depth == '0);
                n_state    = rita_pkg::ST_EMIT;
            end
            rita_pkg::ST_EMIT: begin
                if (i_ready) begin
                    n_state = r_out_last ? rita_pkg::ST_IDLE : rita_pkg::ST_POP;
                end
            end
            default: begin
                n_state = rita_pkg::ST_IDLE;
            end
        endcase
    end

    rita_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (rita_pkg::to_ascii(r_rem)),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_ready      = (r_state == rita_pkg::ST_IDLE);
    assign o_valid      = (r_state == rita_pkg::ST_EMIT);
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

    // input and output sides are never open at once
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output handshake open together");

    // the final digit beat returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_digit) |=> o_ready)
        else $error("block not idle after final digit");

    // stack never overfills
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DIGITS))
        else $error("digit stack depth out of range");

    // divisor stays in the supported range while dividing
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rita_pkg::ST_DIV) |->
            (r_radix_eff >= rita_pkg::RADIX_MIN && r_radix_eff <= rita_pkg::RADIX_MAX))
        else $error("effective radix out of range");

endmodule
`default_nettype wire
